// ===== sv/qai_pkg.sv =====
// Shared types, constants and the derivative term table for the attitude integrator.
// Depends on nothing; imported by the top level.
package qai_pkg;

	// 1.0 in the Q1.14 attitude format
	localparam int unsigned OneQ14 = 16384;
	// reset value of the time step, about 10 ms in units of 2^-16 s
	localparam logic [15:0] StepReset = 16'd655;
	// products in the derivative, square root iterations, quotient bits
	localparam int unsigned NumTerms = 12;
	localparam int unsigned SqrtSteps = 27;
	localparam int unsigned QuoBits = 16;

	// Component and rate indexes
	localparam logic [1:0] CompW = 2'd0;
	localparam logic [1:0] CompX = 2'd1;
	localparam logic [1:0] CompY = 2'd2;
	localparam logic [1:0] CompZ = 2'd3;
	localparam logic [1:0] RateX = 2'd0;
	localparam logic [1:0] RateY = 2'd1;
	localparam logic [1:0] RateZ = 2'd2;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DERIV,
		ST_INC,
		ST_SQR,
		ST_CHK,
		ST_SQRT,
		ST_DIVL,
		ST_DIV
	} state_t;

	// One product of the quaternion-times-rate derivative
	typedef struct packed {
		logic [1:0] acc;
		logic [1:0] qi;
		logic [1:0] wi;
		logic       neg;
	} term_t;

	function automatic term_t deriv_term(input logic [3:0] k);
		term_t t;
		t = '{acc: CompW, qi: CompX, wi: RateX, neg: 1'b1};
		case (k)
			4'd0:  t = '{acc: CompW, qi: CompX, wi: RateX, neg: 1'b1};
			4'd1:  t = '{acc: CompW, qi: CompY, wi: RateY, neg: 1'b1};
			4'd2:  t = '{acc: CompW, qi: CompZ, wi: RateZ, neg: 1'b1};
			4'd3:  t = '{acc: CompX, qi: CompW, wi: RateX, neg: 1'b0};
			4'd4:  t = '{acc: CompX, qi: CompY, wi: RateZ, neg: 1'b0};
			4'd5:  t = '{acc: CompX, qi: CompZ, wi: RateY, neg: 1'b1};
			4'd6:  t = '{acc: CompY, qi: CompW, wi: RateY, neg: 1'b0};
			4'd7:  t = '{acc: CompY, qi: CompX, wi: RateZ, neg: 1'b1};
			4'd8:  t = '{acc: CompY, qi: CompZ, wi: RateX, neg: 1'b0};
			4'd9:  t = '{acc: CompZ, qi: CompW, wi: RateZ, neg: 1'b0};
			4'd10: t = '{acc: CompZ, qi: CompX, wi: RateY, neg: 1'b0};
			4'd11: t = '{acc: CompZ, qi: CompY, wi: RateX, neg: 1'b1};
			default: t = '{acc: CompW, qi: CompX, wi: RateX, neg: 1'b1};
		endcase
		return t;
	endfunction

endpackage

// ===== sv/quaternion_attitude_integrator_top.sv =====
// Attitude quaternion integrator: Euler step of q' = 0.5*q*(0,w), then renormalize.
// One shared multiplier, a bit-serial square root and a restoring divider.
// Depends on qai_pkg.
// The held quaternion is registered onto the output when the item is accepted and
// appears in the cycle after. A new item waits until the shared units have finished
// the multiply/accumulate, increment, square, check, square root and divide steps.
// Reset: quaternion goes to identity (16384,0,0,0), step to 655, output empty.
module quaternion_attitude_integrator_top (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic signed [15:0] rate_x,
	input  logic signed [15:0] rate_y,
	input  logic signed [15:0] rate_z,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [15:0] quat_w,
	output logic signed [15:0] quat_x,
	output logic signed [15:0] quat_y,
	output logic signed [15:0] quat_z,
	input  logic               cfg_wr_en,
	input  logic [15:0]        cfg_wr_data
);
	import qai_pkg::*;

	state_t state_q, state_d;
	logic [4:0] cnt_q, cnt_d;
	logic       ph_q, ph_d;
	logic [1:0] idx_q;
	logic       in_acc;

	logic [15:0]        step_q;
	logic signed [15:0] q_q [4];
	logic signed [15:0] w_q [3];
	logic signed [31:0] s_q [4];
	logic signed [18:0] n_q [4];
	logic [37:0]        n2_q;
	logic [53:0]        v_q, root_q, bit_q;
	logic [40:0]        rem_q;
	logic [41:0]        dsh_q;
	logic [15:0]        quo_q;
	logic signed [50:0] mul_q;
	logic               out_valid_q;

	term_t              term;
	logic signed [31:0] mul_a;
	logic signed [18:0] mul_b;
	logic [50:0]        pmag, prnd;
	logic signed [18:0] r19, inc;
	logic [53:0]        sq_try;
	logic               sq_ge, dv_ge;
	logic [15:0]        quo_fin, quo_sat;
	logic signed [18:0] n_sel, n_mag;

	assign term   = deriv_term(cnt_q[3:0]);
	assign in_acc = in_valid && !in_stall;
	assign out_valid = out_valid_q;

	// Next state and handshake
	always_comb begin
		state_d  = state_q;
		cnt_d    = cnt_q;
		ph_d     = 1'b0;
		in_stall = 1'b1;
		case (state_q)
			ST_IDLE: begin
				in_stall = out_valid_q && out_stall;
				cnt_d    = '0;
				if (in_valid && !(out_valid_q && out_stall)) state_d = ST_DERIV;
			end
			ST_DERIV: begin
				ph_d = ~ph_q;
				if (ph_q) cnt_d = cnt_q + 5'd1;
				if (ph_q && cnt_q == 5'(NumTerms - 1)) begin
					state_d = ST_INC;
					cnt_d   = '0;
				end
			end
			ST_INC, ST_SQR: begin
				ph_d = ~ph_q;
				if (ph_q) cnt_d = cnt_q + 5'd1;
				if (ph_q && cnt_q == 5'd3) begin
					state_d = (state_q == ST_INC) ? ST_SQR : ST_CHK;
					cnt_d   = '0;
				end
			end
			ST_CHK: begin
				cnt_d   = '0;
				state_d = (n2_q == '0) ? ST_IDLE : ST_SQRT;
			end
			ST_SQRT: begin
				cnt_d = cnt_q + 5'd1;
				if (cnt_q == 5'(SqrtSteps - 1)) begin
					state_d = ST_DIVL;
					cnt_d   = '0;
				end
			end
			ST_DIVL: begin
				cnt_d   = '0;
				state_d = ST_DIV;
			end
			ST_DIV: begin
				cnt_d = cnt_q + 5'd1;
				if (cnt_q == 5'(QuoBits - 1)) begin
					cnt_d   = '0;
					state_d = (idx_q == CompZ) ? ST_IDLE : ST_DIVL;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Shared multiplier operand select
	always_comb begin
		mul_a = 32'(q_q[term.qi]);
		mul_b = 19'(w_q[term.wi]);
		case (state_q)
			ST_INC: begin
				mul_a = s_q[cnt_q[1:0]];
				mul_b = signed'({3'b000, step_q});
			end
			ST_SQR: begin
				mul_a = 32'(n_q[cnt_q[1:0]]);
				mul_b = n_q[cnt_q[1:0]];
			end
			default: begin
				mul_a = 32'(q_q[term.qi]);
				mul_b = 19'(w_q[term.wi]);
			end
		endcase
	end

	// Increment: round product / 2^29 to nearest, ties away from zero
	always_comb begin
		pmag = mul_q[50] ? 51'(-mul_q) : 51'(mul_q);
		prnd = pmag + (51'(1) << 28);
		r19  = signed'({1'b0, prnd[46:29]});
		inc  = mul_q[50] ? -r19 : r19;
	end

	// Square root step and divide step
	always_comb begin
		sq_try  = root_q + bit_q;
		sq_ge   = v_q >= sq_try;
		dv_ge   = {1'b0, rem_q} >= dsh_q;
		quo_fin = {quo_q[14:0], dv_ge};
		quo_sat = (quo_fin > 16'(OneQ14)) ? 16'(OneQ14) : quo_fin;
		n_sel   = n_q[idx_q];
		n_mag   = n_sel[18] ? -n_sel : n_sel;
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			ph_q        <= 1'b0;
			idx_q       <= '0;
			step_q      <= StepReset;
			out_valid_q <= 1'b0;
			q_q[0]      <= 16'(OneQ14);
			q_q[1]      <= '0;
			q_q[2]      <= '0;
			q_q[3]      <= '0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			ph_q    <= ph_d;
			if (cfg_wr_en) step_q <= cfg_wr_data;
			// hold the result until taken, load a new one on accept
			if (in_acc) out_valid_q <= 1'b1;
			else if (!out_stall) out_valid_q <= 1'b0;
			if (state_q == ST_CHK) idx_q <= '0;
			if (state_q == ST_DIV && cnt_q == 5'(QuoBits - 1)) begin
				idx_q      <= idx_q + 2'd1;
				q_q[idx_q] <= n_sel[18] ? -signed'(quo_sat) : signed'(quo_sat);
			end
			// zero norm leaves an all-zero quaternion
			if (state_q == ST_CHK && n2_q == '0) begin
				q_q[0] <= '0;
				q_q[1] <= '0;
				q_q[2] <= '0;
				q_q[3] <= '0;
			end
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		mul_q <= mul_a * mul_b;
		if (in_acc) begin
			quat_w <= q_q[0];
			quat_x <= q_q[1];
			quat_y <= q_q[2];
			quat_z <= q_q[3];
			w_q[0] <= rate_x;
			w_q[1] <= rate_y;
			w_q[2] <= rate_z;
			for (int i = 0; i < 4; i++) s_q[i] <= '0;
			n2_q <= '0;
		end
		// accumulate the derivative sums
		if (state_q == ST_DERIV && ph_q) begin
			s_q[term.acc] <= term.neg ? s_q[term.acc] - mul_q[31:0]
				: s_q[term.acc] + mul_q[31:0];
		end
		// add rounded increment
		if (state_q == ST_INC && ph_q) n_q[cnt_q[1:0]] <= 19'(q_q[cnt_q[1:0]]) + inc;
		// sum of squares
		if (state_q == ST_SQR && ph_q) n2_q <= n2_q + mul_q[37:0];
		// start square root on (sum of squares) * 2^16
		if (state_q == ST_CHK) begin
			v_q    <= {n2_q, 16'b0};
			root_q <= '0;
			bit_q  <= 54'(1) << 52;
		end
		// one result bit per cycle
		if (state_q == ST_SQRT) begin
			if (sq_ge) begin
				v_q    <= v_q - sq_try;
				root_q <= (root_q >> 1) + bit_q;
			end else begin
				root_q <= root_q >> 1;
			end
			bit_q <= bit_q >> 2;
		end
		// load divider: |c| * 2^22 + norm/2 over norm
		if (state_q == ST_DIVL) begin
			rem_q <= {n_mag[17:0], 22'b0} + 41'(root_q[26:1]);
			dsh_q <= {root_q[26:0], 15'b0};
			quo_q <= '0;
		end
		if (state_q == ST_DIV) begin
			if (dv_ge) rem_q <= rem_q - dsh_q[40:0];
			dsh_q <= dsh_q >> 1;
			quo_q <= quo_fin;
		end
	end

	// Checks
	a_busy_stalls: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |-> in_stall) else $error("input taken while busy");
	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> (state_q == ST_DERIV && out_valid_q)) else $error("accept did not start");
	a_sqrt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SQRT) |-> (cnt_q < 5'(SqrtSteps))) else $error("sqrt overrun");
	a_zero_norm: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CHK && n2_q == '0) |=> (q_q[0] == '0 && q_q[3] == '0))
		else $error("zero norm not kept");

endmodule
